### hw/rtl/pfs_pkg.sv
// Shared types and constants for the smallest-prime-factor factoriser.
// No dependencies; imported by every module of the block.
package pfs_pkg;

    localparam int unsigned MAX_VALUE   = 65535;
    localparam int unsigned DATA_W      = 16;
    localparam int unsigned ADDR_W      = DATA_W;
    localparam int unsigned TABLE_DEPTH = 1 << ADDR_W;
    // Sieve never runs past the largest value an input can carry
    localparam int unsigned SIEVE_LIMIT =
        (MAX_VALUE < TABLE_DEPTH - 1) ? MAX_VALUE : TABLE_DEPTH - 1;

    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

    // Queue depth must be a power of two so the pointers wrap naturally
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned DIV_RADIX_BITS = 2;
    localparam int unsigned DIV_CYCLES     = DATA_W / DIV_RADIX_BITS;
    localparam int unsigned DIV_CNT_W      = $clog2(DIV_CYCLES);

    localparam logic [2*DATA_W-1:0] SQ_LIMIT = (2*DATA_W)'(SIEVE_LIMIT);
    localparam logic [DATA_W:0]     M_LIMIT  = (DATA_W+1)'(SIEVE_LIMIT);

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } lookup_req_t;

    typedef struct packed {
        word_t value;
        logic  empty;
    } job_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef enum logic [2:0] {
        T_INIT,
        T_PCHECK,
        T_PWAIT,
        T_MRD,
        T_MWAIT,
        T_DONE
    } tbl_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_WAIT,
        B_DIV,
        B_EMIT
    } back_state_t;

endpackage

### hw/rtl/pfs_table.sv
// Smallest-prime-factor table: fill pass, sieve sequencer and lookup port.
// Depends on pfs_pkg.
module pfs_table
    import pfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lookup_req_t lookup,
    output word_t       lookup_data,
    output logic        ready
);

    word_t mem [TABLE_DEPTH];

    tbl_state_t        state_reg, state_next;
    logic [ADDR_W:0]   idx_reg, idx_next;
    word_t             p_reg, p_next;
    logic [DATA_W:0]   m_reg, m_next;
    logic [2*DATA_W-1:0] p_sq;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    word_t             wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    word_t             rd_data_reg;

    assign p_sq = {{DATA_W{1'b0}}, p_reg} * {{DATA_W{1'b0}}, p_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_INIT;
            idx_reg   <= '0;
            p_reg     <= word_t'(2);
            m_reg     <= (DATA_W+1)'(4);
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            p_reg     <= p_next;
            m_reg     <= m_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        p_next     = p_reg;
        m_next     = m_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[ADDR_W-1:0];
        wr_data    = idx_reg[DATA_W-1:0];
        rd_en      = 1'b0;
        rd_addr    = lookup.addr;

        case (state_reg)
            T_INIT:
            begin
                // every entry starts as its own index
                wr_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (ADDR_W+1)'(TABLE_DEPTH - 1))
                begin
                    state_next = T_PCHECK;
                end
            end
            T_PCHECK:
            begin
                if (p_sq > SQ_LIMIT)
                begin
                    state_next = T_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = p_reg[ADDR_W-1:0];
                    state_next = T_PWAIT;
                end
            end
            T_PWAIT:
            begin
                // still unmarked means prime: sweep its multiples from p*p
                if (rd_data_reg == p_reg)
                begin
                    m_next     = p_sq[DATA_W:0];
                    state_next = T_MRD;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = T_PCHECK;
                end
            end
            T_MRD:
            begin
                if (m_reg > M_LIMIT)
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = T_PCHECK;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = m_reg[ADDR_W-1:0];
                    state_next = T_MWAIT;
                end
            end
            T_MWAIT:
            begin
                // first prime to reach an entry keeps it
                if (rd_data_reg == m_reg[DATA_W-1:0])
                begin
                    wr_en   = 1'b1;
                    wr_addr = m_reg[ADDR_W-1:0];
                    wr_data = p_reg;
                end
                m_next     = m_reg + {1'b0, p_reg};
                state_next = T_MRD;
            end
            T_DONE:
            begin
                rd_en   = lookup.en;
                rd_addr = lookup.addr;
            end
            default:
            begin
                state_next = T_INIT;
            end
        endcase
    end

    assign lookup_data = rd_data_reg;
    assign ready       = (state_reg == T_DONE);

endmodule

### hw/rtl/pfs_div.sv
// Iterative restoring divider, DIV_RADIX_BITS quotient bits per cycle.
// Depends on pfs_pkg.
module pfs_div
    import pfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output logic     done,
    output word_t    quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W:0]      rem_reg;
    word_t                quo_reg;
    word_t                dsr_reg;

    logic [DATA_W:0]      rem_step;
    word_t                quo_step;

    always_comb
    begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            // remainder stays below the divisor, so the dropped top bit is zero
            rem_step = {rem_step[DATA_W-1:0], quo_step[DATA_W-1]};
            if (rem_step >= {1'b0, dsr_reg})
            begin
                rem_step = rem_step - {1'b0, dsr_reg};
                quo_step = {quo_step[DATA_W-2:0], 1'b1};
            end
            else
            begin
                quo_step = {quo_step[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/pfs_front.sv
// Front end: accepts input values, flags 0 and 1 as empty, and queues jobs.
// Depends on pfs_pkg.
module pfs_front
    import pfs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  word_t value,
    input  logic  table_ready,
    input  logic  pop,
    output logic  job_valid,
    output job_t  job
);

    job_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              push;
    job_t              job_in;

    assign req_ready = table_ready && (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = req_valid && req_ready;
    assign job_valid = (cnt_reg != '0);
    assign job       = q_mem[rd_ptr_reg];

    always_comb
    begin
        job_in.value = value;
        job_in.empty = (value <= word_t'(1));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

### hw/rtl/pfs_back.sv
// Back end: factors queued jobs by table lookup and division, and holds
// each result in an output register. Depends on pfs_pkg and pfs_div.
module pfs_back
    import pfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        pop,
    output lookup_req_t lookup,
    input  word_t       lookup_data,
    output logic        res_valid,
    input  logic        res_ready,
    output word_t       factor,
    output logic        empty_res,
    output logic        last
);

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    word_t            residual_reg, residual_next;
    word_t            p_reg, p_next;
    word_t            pend_factor_reg, pend_factor_next;
    logic             pend_empty_reg, pend_empty_next;
    logic             pend_last_reg, pend_last_next;

    logic             out_valid_reg;
    word_t            out_factor_reg;
    logic             out_empty_reg;
    logic             out_last_reg;
    logic             load_out;
    logic             slot_free;

    div_req_t         div_req;
    logic             div_done;
    word_t            quotient;
    word_t            p_sel;

    pfs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    assign slot_free = !out_valid_reg || res_ready;
    // an entry below two cannot hold a factor: take the residual whole
    assign p_sel     = (lookup_data < word_t'(2)) ? residual_reg : lookup_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        residual_reg    <= residual_next;
        p_reg           <= p_next;
        pend_factor_reg <= pend_factor_next;
        pend_empty_reg  <= pend_empty_next;
        pend_last_reg   <= pend_last_next;
        if (load_out)
        begin
            out_factor_reg <= pend_factor_reg;
            out_empty_reg  <= pend_empty_reg;
            out_last_reg   <= pend_last_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        residual_next    = residual_reg;
        p_next           = p_reg;
        pend_factor_next = pend_factor_reg;
        pend_empty_next  = pend_empty_reg;
        pend_last_next   = pend_last_reg;
        pop              = 1'b0;
        load_out         = 1'b0;
        lookup.en        = 1'b0;
        lookup.addr      = residual_reg[ADDR_W-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = residual_reg;
        div_req.divisor  = p_sel;

        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    pop           = 1'b1;
                    residual_next = job.value;
                    count_next    = '0;
                    if (job.empty)
                    begin
                        pend_factor_next = '0;
                        pend_empty_next  = 1'b1;
                        pend_last_next   = 1'b1;
                        state_next       = B_EMIT;
                    end
                    else
                    begin
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                lookup.en  = 1'b1;
                state_next = B_WAIT;
            end
            B_WAIT:
            begin
                p_next        = p_sel;
                div_req.start = 1'b1;
                state_next    = B_DIV;
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    residual_next    = quotient;
                    pend_factor_next = p_reg;
                    pend_empty_next  = 1'b0;
                    pend_last_next   = (quotient <= word_t'(1))
                                    || (count_reg == CNT_W'(MAX_RESULTS - 1));
                    state_next       = B_EMIT;
                end
            end
            B_EMIT:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    load_out = 1'b1;
                    if (pend_last_reg)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign res_valid = out_valid_reg;
    assign factor    = out_factor_reg;
    assign empty_res = out_empty_reg;
    assign last      = out_last_reg;

endmodule

### hw/rtl/prime_factorizer_spf_table_top.sv
// Smallest-prime-factor factoriser, top level. Depends on pfs_pkg,
// pfs_table, pfs_front and pfs_back.
// Reset fills all 65536 table entries, then the sieve marks the multiples of each prime;
// req_ready stays low until the table is built. Per prime factor, an item takes a table
// read, a divide by the iterative divider at 2 bits a cycle, and an output load;
// 0 or 1 goes straight to the output load.
// One item is factored at a time; a two-entry queue takes further items meanwhile.
module prime_factorizer_spf_table_top
    import pfs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  word_t value,
    output logic  res_valid,
    input  logic  res_ready,
    output word_t factor,
    output logic  empty_res,
    output logic  last
);

    lookup_req_t lookup;
    word_t       lookup_data;
    logic        table_ready;
    logic        job_valid;
    job_t        job;
    logic        pop;

    pfs_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup      (lookup),
        .lookup_data (lookup_data),
        .ready       (table_ready)
    );

    pfs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .value       (value),
        .table_ready (table_ready),
        .pop         (pop),
        .job_valid   (job_valid),
        .job         (job)
    );

    pfs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (job),
        .pop         (pop),
        .lookup      (lookup),
        .lookup_data (lookup_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .factor      (factor),
        .empty_res   (empty_res),
        .last        (last)
    );

endmodule

### hw/rtl/pfs_checker.sv
// Port-level checks for the factoriser, bound to the top level.
// Depends on pfs_pkg and prime_factorizer_spf_table_top.
module pfs_checker
    import pfs_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  req_valid,
    input logic  req_ready,
    input word_t value,
    input logic  res_valid,
    input logic  res_ready,
    input word_t factor,
    input logic  empty_res,
    input logic  last
);

    // a stalled result transfer keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(factor)
                                    && $stable(empty_res) && $stable(last))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && empty_res |-> factor == '0)
        else $error("empty result carries a factor");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && empty_res |-> last)
        else $error("empty result not marked last");

    a_factor_min: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !empty_res |-> factor >= word_t'(2))
        else $error("factor below two");

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !$isunknown(value))
        else $error("input transfer with undriven value");

endmodule

bind prime_factorizer_spf_table_top pfs_checker u_checker (.*);

### dv/testbench.sv
// Self-checking testbench for prime_factorizer_spf_table_top: drives values to factor,
// predicts the prime factors from its own sieve table and checks every result transfer.
// Depends on pfs_pkg and the RTL of the block only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pfs_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 250;
    localparam int unsigned RANDOM_ITEMS = 130;
    localparam int unsigned SMALL_PRIMES[6] = '{2, 3, 5, 7, 11, 13};
    localparam word_t EDGE_VALUES[18] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd65535, 16'd65534, 16'd65521,
        16'd32768, 16'd49152, 16'd63001, 16'd65498, 16'd43690, 16'd21845,
        16'd30030, 16'd65025, 16'd32767, 16'd255
    };

    typedef struct packed {
        word_t factor;
        logic  empty;
        logic  last;
    } factor_res_t;

    class spf_scoreboard;
        word_t       smallest_factor[TABLE_DEPTH];
        factor_res_t awaited[$];
        int unsigned errors;

        function new();
            int unsigned p;
            int unsigned m;
            for (int unsigned i = 0; i < TABLE_DEPTH; i++)
                smallest_factor[i] = word_t'(i);
            for (p = 2; p * p <= SIEVE_LIMIT; p++)
            begin
                if (smallest_factor[p] == word_t'(p))
                begin
                    for (m = p * p; m <= SIEVE_LIMIT; m += p)
                        if (smallest_factor[m] == word_t'(m))
                            smallest_factor[m] = word_t'(p);
                end
            end
            errors = 0;
        endfunction

        // Factor by repeated lookup and division; mark the final factor as last
        function void note_value(word_t v);
            int unsigned rest;
            int unsigned p;
            int unsigned n;
            factor_res_t r;
            rest = 32'(v);
            if (rest <= 1)
            begin
                r.factor = '0;
                r.empty  = 1'b1;
                r.last   = 1'b1;
                awaited.push_back(r);
                return;
            end
            n = 0;
            while (rest > 1 && n < MAX_RESULTS)
            begin
                p = 32'(smallest_factor[rest]);
                // an entry the sieve never reached stands for itself
                if (p < 2)
                    p = rest;
                rest = rest / p;
                n++;
                r.factor = word_t'(p);
                r.empty  = 1'b0;
                r.last   = (rest <= 1) || (n == MAX_RESULTS);
                awaited.push_back(r);
            end
        endfunction

        function void check_result(word_t f, logic e, logic l);
            factor_res_t r;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result factor=%0d empty_res=%b last=%b",
                         $time, f, e, l);
                return;
            end
            r = awaited.pop_front();
            if (f !== r.factor)
            begin
                errors++;
                $display("%0t: factor expected %0d actual %0d", $time, r.factor, f);
            end
            if (e !== r.empty)
            begin
                errors++;
                $display("%0t: empty_res expected %b actual %b", $time, r.empty, e);
            end
            if (l !== r.last)
            begin
                errors++;
                $display("%0t: last expected %b actual %b", $time, r.last, l);
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    word_t value;
    logic  res_valid;
    logic  res_ready;
    word_t factor;
    logic  empty_res;
    logic  last;

    int unsigned   tx_idle_pct;
    int unsigned   rx_idle_pct;
    bit            hold_off_req;
    int unsigned   cycle_count;
    spf_scoreboard factor_board;

    prime_factorizer_spf_table_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .value     (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .factor    (factor),
        .empty_res (empty_res),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            factor_board.check_result(factor, empty_res, last);
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic offer_value(input word_t v);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        req_valid <= 1'b1;
        value     <= v;
        do @(posedge clk); while (!req_ready);
        factor_board.note_value(v);
    endtask

    // Drop valid and hold until every predicted factor has arrived
    task automatic await_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (factor_board.pending() != 0);
    endtask

    function automatic word_t pick_value();
        int unsigned prod;
        int unsigned p;
        case ($urandom_range(0, 9))
            5: return word_t'($urandom_range(0, 15));
            6, 7:
            begin
                prod = 1;
                repeat ($urandom_range(1, 14))
                begin
                    p = SMALL_PRIMES[$urandom_range(0, 5)];
                    if (prod * p <= 65535)
                        prod *= p;
                end
                return word_t'(prod);
            end
            8: return word_t'($urandom_range(32768, 65535));
            9: return word_t'($urandom_range(1, 3) << $urandom_range(0, 14));
            default: return word_t'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        factor_board = new();
        cycle_count  = 0;
        hold_off_req = 1'b0;
        tx_idle_pct  = 33;
        rx_idle_pct  = 60;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        value        = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles a third of the time, receiver more than half
        foreach (EDGE_VALUES[k])
            offer_value(EDGE_VALUES[k]);
        repeat (20) offer_value(pick_value());
        hold_off_req = 1'b1;
        repeat (15) offer_value(pick_value());
        await_results();
        repeat (20) offer_value(pick_value());

        tx_idle_pct = 60;
        rx_idle_pct = 33;
        repeat (RANDOM_ITEMS / 3) offer_value(pick_value());

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (RANDOM_ITEMS / 3) offer_value(pick_value());

        await_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (factor_board.errors == 0 && factor_board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
